>>> design/great_circle_distance_assert.svh
// Assertion macros used by great_circle_distance.sv.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GCD_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define GCD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define GCD_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define GCD_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define GCD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

>>> design/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES = 24;

    localparam int STEP_W = 5;
    localparam int DEG_W = 26;
    localparam int XY_W = 34;
    localparam int PROD_W = 36;
    localparam int ROOT_W = 63;
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_OUT_W = 31;
    localparam int DIST_W = 15;

    // Degrees to binary angle: full angles shift by TURN_SHIFT, half angles by one more.
    localparam int TURN_SHIFT = ANGLE_FRAC_BITS + 8;

    localparam logic [31:0] DEG_TO_TURN = 32'd3054198966;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [ROOT_OUT_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [ROOT_W-1:0] ROOT_MSB = {1'b1, 62'b0};
    localparam logic [32:0] DIST_SCALE = 33'h1_38BC_58E1;
    localparam logic [15:0] DIST_SCALE_LO = DIST_SCALE[15:0];
    localparam logic [16:0] DIST_SCALE_HI = DIST_SCALE[32:16];
    localparam logic [DIST_W-1:0] DIST_MAX = 15'd20015;

    // Pipeline positions.
    localparam int IDX_ROT0 = 3;
    localparam int IDX_M1 = IDX_ROT0 + CORDIC_STAGES;
    localparam int IDX_A = IDX_M1 + 2;
    localparam int IDX_ROOT0 = IDX_A + 1;
    localparam int IDX_VEC0 = IDX_ROOT0 + ROOT_STEPS;
    localparam int IDX_THETA = IDX_VEC0 + CORDIC_STAGES;
    localparam int NSTAGE = IDX_THETA + 3;

    // atan(2^-i) in units of 2^-32 turn, truncated.
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051D;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2E;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000000;
            5'd31: r = 32'h00000000;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/gcd_rot_cell.sv
`default_nettype none
module gcd_rot_cell
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [gcd_pkg::STEP_W-1:0]          stage,
    input  logic signed [gcd_pkg::XY_W-1:0]     x_in,
    input  logic signed [gcd_pkg::XY_W-1:0]     y_in,
    input  logic signed [gcd_pkg::XY_W-1:0]     z_in,
    input  logic [1:0]                          q_in,
    output logic signed [gcd_pkg::XY_W-1:0]     x_out,
    output logic signed [gcd_pkg::XY_W-1:0]     y_out,
    output logic signed [gcd_pkg::XY_W-1:0]     z_out,
    output logic [1:0]                          q_out
);

    logic signed [gcd_pkg::XY_W-1:0] xs;
    logic signed [gcd_pkg::XY_W-1:0] ys;
    logic signed [gcd_pkg::XY_W-1:0] at;
    logic signed [gcd_pkg::XY_W-1:0] x_next;
    logic signed [gcd_pkg::XY_W-1:0] y_next;
    logic signed [gcd_pkg::XY_W-1:0] z_next;
    logic signed [gcd_pkg::XY_W-1:0] x_reg;
    logic signed [gcd_pkg::XY_W-1:0] y_reg;
    logic signed [gcd_pkg::XY_W-1:0] z_reg;
    logic [1:0]                      q_reg;

    always_comb
    begin
        xs = x_in >>> stage;
        ys = y_in >>> stage;
        at = $signed({2'b00, gcd_pkg::atan_turn(stage)});
        if (z_in >= 0)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            q_reg <= q_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign q_out = q_reg;

endmodule
`default_nettype wire

>>> design/gcd_root_cell.sv
`default_nettype none
module gcd_root_cell
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcd_pkg::STEP_W-1:0]    stage,
    input  logic [gcd_pkg::ROOT_W-1:0]    v_in,
    input  logic [gcd_pkg::ROOT_W-1:0]    r_in,
    output logic [gcd_pkg::ROOT_W-1:0]    v_out,
    output logic [gcd_pkg::ROOT_W-1:0]    r_out
);

    logic [gcd_pkg::ROOT_W-1:0] bitv;
    logic [gcd_pkg::ROOT_W-1:0] trial;
    logic [gcd_pkg::ROOT_W-1:0] v_next;
    logic [gcd_pkg::ROOT_W-1:0] r_next;
    logic [gcd_pkg::ROOT_W-1:0] v_reg;
    logic [gcd_pkg::ROOT_W-1:0] r_reg;

    // The trial bit moves down two places per cell.
    always_comb
    begin
        bitv = gcd_pkg::ROOT_MSB >> {stage, 1'b0};
        trial = r_in + bitv;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + bitv;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule
`default_nettype wire

>>> design/gcd_vec_cell.sv
`default_nettype none
module gcd_vec_cell
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [gcd_pkg::STEP_W-1:0]          stage,
    input  logic signed [gcd_pkg::XY_W-1:0]     x_in,
    input  logic signed [gcd_pkg::XY_W-1:0]     y_in,
    input  logic signed [gcd_pkg::XY_W-1:0]     z_in,
    output logic signed [gcd_pkg::XY_W-1:0]     x_out,
    output logic signed [gcd_pkg::XY_W-1:0]     y_out,
    output logic signed [gcd_pkg::XY_W-1:0]     z_out
);

    logic signed [gcd_pkg::XY_W-1:0] xs;
    logic signed [gcd_pkg::XY_W-1:0] ys;
    logic signed [gcd_pkg::XY_W-1:0] at;
    logic signed [gcd_pkg::XY_W-1:0] x_next;
    logic signed [gcd_pkg::XY_W-1:0] y_next;
    logic signed [gcd_pkg::XY_W-1:0] z_next;
    logic signed [gcd_pkg::XY_W-1:0] x_reg;
    logic signed [gcd_pkg::XY_W-1:0] y_reg;
    logic signed [gcd_pkg::XY_W-1:0] z_reg;

    // Each cell turns the vector toward the x axis and sums the angle.
    always_comb
    begin
        xs = x_in >>> stage;
        ys = y_in >>> stage;
        at = $signed({2'b00, gcd_pkg::atan_turn(stage)});
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

>>> design/great_circle_distance.sv
// Haversine distance between two points on a sphere of radius 6371 km.
// Input channel: in_valid, in_stall and the four coordinates in signed degrees
// with 16 fraction bits. A transfer happens when in_valid is high and in_stall low.
// Output channel: out_valid, out_stall and distance_km in whole kilometres.
// One pair enters per cycle while in_stall is low, and every pair gives exactly one result.
// The pipeline runs angle conversion, a rotation chain of one cell per
// CORDIC stage, the haversine multiplies, a 32-cell square-root chain, a
// vectoring chain of one cell per stage, and clamp and scaling.
// Throughput is one transfer per cycle for as long as the receiver takes results.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped.
// Reset clears every valid bit, so no result appears until pairs are sent.
`default_nettype none
`include "great_circle_distance_assert.svh"
module great_circle_distance
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [23:0]             lat_first,
    input  logic signed [24:0]             lon_first,
    input  logic signed [23:0]             lat_second,
    input  logic signed [24:0]             lon_second,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gcd_pkg::DIST_W-1:0]     distance_km
);

    localparam int CS = gcd_pkg::CORDIC_STAGES;
    localparam int XW = gcd_pkg::XY_W;
    localparam int RW = gcd_pkg::ROOT_W;

    logic adv;
    logic [gcd_pkg::NSTAGE-1:0] vld_reg;
    logic [gcd_pkg::NSTAGE-1:0] vld_next;

    assign adv = !(vld_reg[gcd_pkg::NSTAGE-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[gcd_pkg::NSTAGE-1];
    assign vld_next = {vld_reg[gcd_pkg::NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Lanes: 0 and 1 give the cosines of the latitudes, 2 and 3 the sines of
    // the half differences in latitude and longitude.
    logic signed [gcd_pkg::DEG_W-1:0] deg_next [4];
    logic signed [gcd_pkg::DEG_W-1:0] deg_reg [4];
    logic signed [XW-1:0] rot_x [4][CS+1];
    logic signed [XW-1:0] rot_y [4][CS+1];
    logic signed [XW-1:0] rot_z [4][CS+1];
    logic [1:0] rot_q [4][CS+1];
    logic signed [XW-1:0] trig [4];

    assign deg_next[0] = {{2{lat_first[23]}}, lat_first};
    assign deg_next[1] = {{2{lat_second[23]}}, lat_second};
    assign deg_next[2] = {{2{lat_first[23]}}, lat_first}
                       - {{2{lat_second[23]}}, lat_second};
    assign deg_next[3] = {lon_first[24], lon_first} - {lon_second[24], lon_second};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg <= deg_next;
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            localparam int SH = gcd_pkg::TURN_SHIFT + ((l < 2) ? 0 : 1);
            logic signed [gcd_pkg::DEG_W+32:0] prod;
            logic signed [gcd_pkg::DEG_W+32:0] prod_sh;
            logic [31:0] turn_reg;
            logic [1:0] q;
            logic [31:0] rem;
            logic signed [XW-1:0] z_reg;
            logic [1:0] q_reg;
            logic signed [XW-1:0] co;
            logic signed [XW-1:0] si;

            assign prod = deg_reg[l] * $signed({1'b0, gcd_pkg::DEG_TO_TURN});
            assign prod_sh = prod >>> SH;
            assign q = 2'((turn_reg + 32'h2000_0000) >> 30);
            assign rem = turn_reg - {q, 30'b0};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    turn_reg <= prod_sh[31:0];
                    z_reg <= {{(XW-32){rem[31]}}, rem};
                    q_reg <= q;
                end
            end

            assign rot_x[l][0] = gcd_pkg::CORDIC_GAIN;
            assign rot_y[l][0] = '0;
            assign rot_z[l][0] = z_reg;
            assign rot_q[l][0] = q_reg;

            for (s = 0; s < CS; s++)
            begin : g_rot
                gcd_rot_cell u_cell
                (
                    .clk   (clk),
                    .en    (adv),
                    .stage (gcd_pkg::STEP_W'(s)),
                    .x_in  (rot_x[l][s]),
                    .y_in  (rot_y[l][s]),
                    .z_in  (rot_z[l][s]),
                    .q_in  (rot_q[l][s]),
                    .x_out (rot_x[l][s+1]),
                    .y_out (rot_y[l][s+1]),
                    .z_out (rot_z[l][s+1]),
                    .q_out (rot_q[l][s+1])
                );
            end

            // Unfold the quadrant taken off before the rotation.
            always_comb
            begin
                unique case (rot_q[l][CS])
                    2'd0:
                    begin
                        co = rot_x[l][CS];
                        si = rot_y[l][CS];
                    end
                    2'd1:
                    begin
                        co = -rot_y[l][CS];
                        si = rot_x[l][CS];
                    end
                    2'd2:
                    begin
                        co = -rot_x[l][CS];
                        si = -rot_y[l][CS];
                    end
                    default:
                    begin
                        co = rot_y[l][CS];
                        si = -rot_x[l][CS];
                    end
                endcase
            end

            assign trig[l] = (l < 2) ? co : si;
        end
    endgenerate

    // Haversine term: a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2).
    logic signed [2*XW-1:0] m_dl;
    logic signed [2*XW-1:0] m_cc;
    logic signed [2*XW-1:0] m_do;
    logic signed [2*XW-1:0] m_dl_sh;
    logic signed [2*XW-1:0] m_cc_sh;
    logic signed [2*XW-1:0] m_do_sh;
    logic signed [gcd_pkg::PROD_W-1:0] sdl2_reg;
    logic signed [gcd_pkg::PROD_W-1:0] cc_reg;
    logic signed [gcd_pkg::PROD_W-1:0] sdo2_reg;
    logic signed [2*gcd_pkg::PROD_W-1:0] m_t;
    logic signed [2*gcd_pkg::PROD_W-1:0] m_t_sh;
    logic signed [gcd_pkg::PROD_W-1:0] a1_reg;
    logic signed [gcd_pkg::PROD_W-1:0] t_reg;
    logic signed [gcd_pkg::PROD_W:0] a_sum;
    logic [gcd_pkg::ROOT_OUT_W-1:0] a_next;
    logic [gcd_pkg::ROOT_OUT_W-1:0] a_reg;

    assign m_dl = trig[2] * trig[2];
    assign m_cc = trig[0] * trig[1];
    assign m_do = trig[3] * trig[3];
    assign m_dl_sh = m_dl >>> 30;
    assign m_cc_sh = m_cc >>> 30;
    assign m_do_sh = m_do >>> 30;
    assign m_t = cc_reg * sdo2_reg;
    assign m_t_sh = m_t >>> 30;
    assign a_sum = {a1_reg[gcd_pkg::PROD_W-1], a1_reg} + {t_reg[gcd_pkg::PROD_W-1], t_reg};

    always_comb
    begin
        priority if (a_sum < 0)
        begin
            a_next = '0;
        end
        else if (a_sum > $signed({6'b0, gcd_pkg::ONE_Q30}))
        begin
            a_next = gcd_pkg::ONE_Q30;
        end
        else
        begin
            a_next = a_sum[gcd_pkg::ROOT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdl2_reg <= m_dl_sh[gcd_pkg::PROD_W-1:0];
            cc_reg <= m_cc_sh[gcd_pkg::PROD_W-1:0];
            sdo2_reg <= m_do_sh[gcd_pkg::PROD_W-1:0];
            a1_reg <= sdl2_reg;
            t_reg <= m_t_sh[gcd_pkg::PROD_W-1:0];
            a_reg <= a_next;
        end
    end

    // Roots of a and 1 - a, each as isqrt of the value shifted up by 30.
    logic [RW-1:0] ry_v [gcd_pkg::ROOT_STEPS+1];
    logic [RW-1:0] ry_r [gcd_pkg::ROOT_STEPS+1];
    logic [RW-1:0] rx_v [gcd_pkg::ROOT_STEPS+1];
    logic [RW-1:0] rx_r [gcd_pkg::ROOT_STEPS+1];
    logic [gcd_pkg::ROOT_OUT_W-1:0] a_cmp;

    assign a_cmp = gcd_pkg::ONE_Q30 - a_reg;
    assign ry_v[0] = {(RW-gcd_pkg::ROOT_OUT_W-30)'(0), a_reg, 30'b0};
    assign rx_v[0] = {(RW-gcd_pkg::ROOT_OUT_W-30)'(0), a_cmp, 30'b0};
    assign ry_r[0] = '0;
    assign rx_r[0] = '0;

    generate
        for (s = 0; s < gcd_pkg::ROOT_STEPS; s++)
        begin : g_root
            gcd_root_cell u_ry
            (
                .clk   (clk),
                .en    (adv),
                .stage (gcd_pkg::STEP_W'(s)),
                .v_in  (ry_v[s]),
                .r_in  (ry_r[s]),
                .v_out (ry_v[s+1]),
                .r_out (ry_r[s+1])
            );
            gcd_root_cell u_rx
            (
                .clk   (clk),
                .en    (adv),
                .stage (gcd_pkg::STEP_W'(s)),
                .v_in  (rx_v[s]),
                .r_in  (rx_r[s]),
                .v_out (rx_v[s+1]),
                .r_out (rx_r[s+1])
            );
        end
    endgenerate

    // Central angle as atan2(sqrt(a), sqrt(1 - a)).
    logic signed [XW-1:0] vec_x [CS+1];
    logic signed [XW-1:0] vec_y [CS+1];
    logic signed [XW-1:0] vec_z [CS+1];

    assign vec_x[0] = {{(XW-gcd_pkg::ROOT_OUT_W){1'b0}},
                       rx_r[gcd_pkg::ROOT_STEPS][gcd_pkg::ROOT_OUT_W-1:0]};
    assign vec_y[0] = {{(XW-gcd_pkg::ROOT_OUT_W){1'b0}},
                       ry_r[gcd_pkg::ROOT_STEPS][gcd_pkg::ROOT_OUT_W-1:0]};
    assign vec_z[0] = '0;

    generate
        for (s = 0; s < CS; s++)
        begin : g_vec
            gcd_vec_cell u_cell
            (
                .clk   (clk),
                .en    (adv),
                .stage (gcd_pkg::STEP_W'(s)),
                .x_in  (vec_x[s]),
                .y_in  (vec_y[s]),
                .z_in  (vec_z[s]),
                .x_out (vec_x[s+1]),
                .y_out (vec_y[s+1]),
                .z_out (vec_z[s+1])
            );
        end
    endgenerate

    // Clamp the angle, then scale by 4 pi R in two partial products.
    logic [gcd_pkg::ROOT_OUT_W-1:0] theta_next;
    logic [gcd_pkg::ROOT_OUT_W-1:0] theta_reg;
    logic [gcd_pkg::ROOT_OUT_W+15:0] plo_reg;
    logic [gcd_pkg::ROOT_OUT_W+16:0] phi_reg;
    logic [63:0] scaled;
    logic [gcd_pkg::DIST_W-1:0] dist_reg;

    always_comb
    begin
        priority if (vec_z[CS] < 0)
        begin
            theta_next = '0;
        end
        else if (vec_z[CS] > $signed({3'b0, gcd_pkg::ONE_Q30}))
        begin
            theta_next = gcd_pkg::ONE_Q30;
        end
        else
        begin
            theta_next = vec_z[CS][gcd_pkg::ROOT_OUT_W-1:0];
        end
    end

    assign scaled = {phi_reg, 16'b0} + {17'b0, plo_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta_reg <= theta_next;
            plo_reg <= theta_reg * gcd_pkg::DIST_SCALE_LO;
            phi_reg <= theta_reg * gcd_pkg::DIST_SCALE_HI;
            dist_reg <= scaled[48 +: gcd_pkg::DIST_W];
        end
    end

    assign distance_km = dist_reg;

    `GCD_ASSERT_IMPLIES(a_dist_range, clk, rst_n, out_valid, distance_km <= gcd_pkg::DIST_MAX, "distance above half circumference")
    `GCD_ASSERT_IMPLIES(a_hav_clamp, clk, rst_n, vld_reg[gcd_pkg::IDX_A], a_reg <= gcd_pkg::ONE_Q30, "haversine term out of range")
    `GCD_ASSERT_IMPLIES(a_theta_clamp, clk, rst_n, vld_reg[gcd_pkg::IDX_THETA], theta_reg <= gcd_pkg::ONE_Q30, "central angle out of range")
    `GCD_ASSERT_NEXT(a_in_enter, clk, rst_n, in_valid && !in_stall, vld_reg[0], "accepted transfer lost at pipeline entry")
    `GCD_ASSERT_ALWAYS(a_stall_freeze, clk, rst_n, !(in_stall && !out_valid), "pipeline held without a waiting result")

endmodule
`default_nettype wire
